### hdl/mrt_pkg.sv
// Shared constants, codes and types of the mapped region table.
package mrt_pkg;

    // Table and address geometry
    localparam int SLOTS      = 16;
    localparam int IDX_W      = $clog2(SLOTS);
    localparam int ADDR_W     = 38;
    localparam int PAGE_BYTES = 4096;
    localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
    localparam int PC_W       = 26;
    localparam int FILE_W     = 8;
    localparam int ST_W       = 3;
    localparam logic [ADDR_W-1:0] MIN_ADDR_RESET = ADDR_W'(64'h4000_0000);
    localparam logic [ADDR_W+1:0] ADDR_TOP = (ADDR_W+2)'(1) << ADDR_W;

    // Request types
    localparam logic [1:0] REQ_MAP   = 2'd0;
    localparam logic [1:0] REQ_UNMAP = 2'd1;
    localparam logic [1:0] REQ_FAULT = 2'd2;

    // Result status codes
    localparam logic [ST_W-1:0] ST_OK       = 3'd0;
    localparam logic [ST_W-1:0] ST_REJECT   = 3'd1;
    localparam logic [ST_W-1:0] ST_NOREGION = 3'd2;
    localparam logic [ST_W-1:0] ST_NOSLOT   = 3'd3;
    localparam logic [ST_W-1:0] ST_NOSPACE  = 3'd4;

    // Result kinds that the controller asks the datapath to form
    localparam logic [2:0] RES_REJECT   = 3'd0;
    localparam logic [2:0] RES_NOREGION = 3'd1;
    localparam logic [2:0] RES_NOSLOT   = 3'd2;
    localparam logic [2:0] RES_NOSPACE  = 3'd3;
    localparam logic [2:0] RES_MAP      = 3'd4;
    localparam logic [2:0] RES_UNMAP    = 3'd5;
    localparam logic [2:0] RES_FAULT    = 3'd6;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic       load;         // capture request, start first scan
        logic       place_step;   // one placement compare, advance index
        logic       pass_restart; // begin another placement pass
        logic       find_step;    // advance lookup index
        logic       res_en;       // form result and update table
        logic [2:0] res_kind;
    } cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic [1:0] req_type;
        logic       map_bad;
        logic       full;
        logic       last;
        logic       moved;
        logic       hit;
        logic       unmap_ok;
        logic       fits;
    } sts_t;

    // One result item
    typedef struct packed {
        logic [ST_W-1:0]   status;
        logic [ADDR_W-1:0] region_addr;
        logic [ADDR_W-1:0] file_offset;
        logic [PC_W-1:0]   page_count;
        logic              perm_read;
        logic              perm_write;
        logic              write_back;
        logic [FILE_W-1:0] file_id_out;
        logic              region_freed;
    } res_t;

endpackage

### hdl/mrt_ctrl.sv
// Controller state machine that sequences checks, scans and table updates.
module mrt_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic          out_free,
    output logic          push,
    input  mrt_pkg::sts_t sts,
    output mrt_pkg::cmd_t cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CHECK = 3'd1;
    localparam logic [2:0] S_PLACE = 3'd2;
    localparam logic [2:0] S_PASS  = 3'd3;
    localparam logic [2:0] S_FIND  = 3'd4;
    localparam logic [2:0] S_OUT   = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign in_ready = (state_reg == S_IDLE);

    // Next state and command decode
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        push       = 1'b0;
        case (state_reg)
            S_IDLE: begin
                if (in_valid) begin
                    cmd.load   = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK: begin
                if (sts.req_type == mrt_pkg::REQ_MAP) begin
                    if (sts.map_bad) begin
                        cmd.res_en   = 1'b1;
                        cmd.res_kind = mrt_pkg::RES_REJECT;
                        state_next   = S_OUT;
                    end else if (sts.full) begin
                        cmd.res_en   = 1'b1;
                        cmd.res_kind = mrt_pkg::RES_NOSLOT;
                        state_next   = S_OUT;
                    end else begin
                        state_next = S_PLACE;
                    end
                end else if (sts.req_type == mrt_pkg::REQ_UNMAP ||
                             sts.req_type == mrt_pkg::REQ_FAULT) begin
                    state_next = S_FIND;
                end else begin
                    cmd.res_en   = 1'b1;
                    cmd.res_kind = mrt_pkg::RES_REJECT;
                    state_next   = S_OUT;
                end
            end
            S_PLACE: begin
                cmd.place_step = 1'b1;
                if (sts.last) begin
                    state_next = S_PASS;
                end
            end
            S_PASS: begin
                // A pass that moved the candidate needs another pass.
                if (sts.moved) begin
                    cmd.pass_restart = 1'b1;
                    state_next       = S_PLACE;
                end else begin
                    cmd.res_en   = 1'b1;
                    cmd.res_kind = sts.fits ? mrt_pkg::RES_MAP : mrt_pkg::RES_NOSPACE;
                    state_next   = S_OUT;
                end
            end
            S_FIND: begin
                if (sts.hit) begin
                    cmd.res_en = 1'b1;
                    if (sts.req_type == mrt_pkg::REQ_FAULT) begin
                        cmd.res_kind = mrt_pkg::RES_FAULT;
                    end else if (sts.unmap_ok) begin
                        cmd.res_kind = mrt_pkg::RES_UNMAP;
                    end else begin
                        cmd.res_kind = mrt_pkg::RES_REJECT;
                    end
                    state_next = S_OUT;
                end else if (sts.last) begin
                    cmd.res_en   = 1'b1;
                    cmd.res_kind = mrt_pkg::RES_NOREGION;
                    state_next   = S_OUT;
                end else begin
                    cmd.find_step = 1'b1;
                end
            end
            S_OUT: begin
                if (out_free) begin
                    push       = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

### hdl/mrt_dp.sv
// Datapath: region table, request registers, placement and lookup logic.
module mrt_dp (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_valid,
    input  logic [mrt_pkg::ADDR_W-1:0]  cfg_data,
    input  logic [127:0]                in_tdata,
    input  logic [1:0]                  in_tuser,
    input  mrt_pkg::cmd_t               cmd,
    output mrt_pkg::sts_t               sts,
    output mrt_pkg::res_t               res
);

    localparam int AW = mrt_pkg::ADDR_W;
    localparam int IW = mrt_pkg::IDX_W;

    logic [AW-1:0] min_addr_reg;

    // Captured request
    logic [1:0]    rq_type_reg;
    logic [AW-1:0] rq_addr_reg;
    logic [AW-1:0] rq_len_reg;
    logic [AW:0]   rq_end_reg;
    logic          rq_bad_reg;
    logic [1:0]    rq_prot_reg;
    logic          rq_shared_reg;
    logic [7:0]    rq_fid_reg;

    // Scan state
    logic [IW-1:0] idx_reg;
    logic [AW:0]   cand_reg;
    logic [AW+1:0] cand_end_reg;
    logic          moved_reg;
    logic [IW-1:0] free_reg;
    logic [IW-1:0] free_next;

    // Region table
    logic          valid_reg [mrt_pkg::SLOTS];
    logic [AW-1:0] base_reg  [mrt_pkg::SLOTS];
    logic [AW-1:0] start_reg [mrt_pkg::SLOTS];
    logic [AW:0]   end_reg   [mrt_pkg::SLOTS];
    logic [1:0]    perm_reg  [mrt_pkg::SLOTS];
    logic          shr_reg   [mrt_pkg::SLOTS];
    logic [7:0]    file_reg  [mrt_pkg::SLOTS];

    // Input field unpacking
    logic [AW-1:0] in_addr;
    logic [AW-1:0] in_len;
    logic [AW-1:0] in_offs;
    logic [1:0]    in_prot;
    logic          in_shared;
    logic          in_rd;
    logic          in_wr;

    assign in_addr   = in_tdata[37:0];
    assign in_len    = in_tdata[75:38];
    assign in_offs   = in_tdata[113:76];
    assign in_prot   = in_tdata[115:114];
    assign in_shared = in_tdata[116];
    assign in_rd     = in_tdata[117];
    assign in_wr     = in_tdata[118];

    // Entry under the scan index
    logic          ent_valid;
    logic [AW-1:0] ent_start;
    logic [AW:0]   ent_end;
    logic [AW-1:0] ent_base;
    logic          at_start;
    logic          overlap;
    logic          all_valid;
    logic [AW-1:0] page;
    mrt_pkg::res_t res_next;

    assign ent_valid = valid_reg[idx_reg];
    assign ent_start = start_reg[idx_reg];
    assign ent_end   = end_reg[idx_reg];
    assign ent_base  = base_reg[idx_reg];
    assign at_start  = (rq_addr_reg == ent_start);
    assign overlap   = ent_valid && ({2'b00, ent_start} < cand_end_reg) &&
                       (ent_end > cand_reg);
    assign page      = {rq_addr_reg[AW-1:mrt_pkg::PAGE_SHIFT],
                        {mrt_pkg::PAGE_SHIFT{1'b0}}};

    // Lowest free slot and table-full flag
    always_comb begin
        free_next = '0;
        all_valid = 1'b1;
        for (int i = mrt_pkg::SLOTS - 1; i >= 0; i--) begin
            if (!valid_reg[i]) begin
                free_next = IW'(i);
                all_valid = 1'b0;
            end
        end
    end

    // Status to the controller
    always_comb begin
        sts.req_type = rq_type_reg;
        sts.map_bad  = rq_bad_reg;
        sts.full     = all_valid;
        sts.last     = (idx_reg == IW'(mrt_pkg::SLOTS - 1));
        sts.moved    = moved_reg;
        sts.hit      = ent_valid && (rq_addr_reg >= ent_start) &&
                       ({1'b0, rq_addr_reg} < ent_end);
        sts.unmap_ok = at_start ? (rq_end_reg <= ent_end) : (rq_end_reg == ent_end);
        sts.fits     = (cand_end_reg <= mrt_pkg::ADDR_TOP);
    end

    // Configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_addr_reg <= mrt_pkg::MIN_ADDR_RESET;
        end else if (cfg_valid) begin
            min_addr_reg <= cfg_data;
        end
    end

    // Request capture and scan registers
    always_ff @(posedge aclk) begin
        free_reg <= free_next;
        if (cmd.load) begin
            rq_type_reg   <= in_tuser;
            rq_addr_reg   <= in_addr;
            rq_len_reg    <= in_len;
            rq_end_reg    <= {1'b0, in_addr} + {1'b0, in_len};
            rq_bad_reg    <= (in_addr != '0) || (in_offs != '0) || (in_len == '0) ||
                             (!in_rd && in_prot[0]) ||
                             (in_shared && !in_wr && in_prot[1]);
            rq_prot_reg   <= in_prot;
            rq_shared_reg <= in_shared;
            rq_fid_reg    <= in_tdata[126:119];
            idx_reg       <= '0;
            moved_reg     <= 1'b0;
            cand_reg      <= {1'b0, min_addr_reg};
            cand_end_reg  <= {2'b00, min_addr_reg} + {2'b00, in_len};
        end else if (cmd.place_step) begin
            // Push the candidate past any region that overlaps it.
            if (overlap) begin
                cand_reg     <= ent_end;
                cand_end_reg <= {1'b0, ent_end} + {2'b00, rq_len_reg};
                moved_reg    <= 1'b1;
            end
            idx_reg <= idx_reg + 1'b1;
        end else if (cmd.pass_restart) begin
            idx_reg   <= '0;
            moved_reg <= 1'b0;
        end else if (cmd.find_step) begin
            idx_reg <= idx_reg + 1'b1;
        end
    end

    // Table valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < mrt_pkg::SLOTS; i++) begin
                valid_reg[i] <= 1'b0;
            end
        end else if (cmd.res_en) begin
            if (cmd.res_kind == mrt_pkg::RES_MAP) begin
                valid_reg[free_reg] <= 1'b1;
            end else if (cmd.res_kind == mrt_pkg::RES_UNMAP && at_start &&
                         rq_end_reg == ent_end) begin
                valid_reg[idx_reg] <= 1'b0;
            end
        end
    end

    // Table payload
    always_ff @(posedge aclk) begin
        if (cmd.res_en) begin
            if (cmd.res_kind == mrt_pkg::RES_MAP) begin
                base_reg[free_reg]  <= cand_reg[AW-1:0];
                start_reg[free_reg] <= cand_reg[AW-1:0];
                end_reg[free_reg]   <= cand_end_reg[AW:0];
                perm_reg[free_reg]  <= rq_prot_reg;
                shr_reg[free_reg]   <= rq_shared_reg;
                file_reg[free_reg]  <= rq_fid_reg;
            end else if (cmd.res_kind == mrt_pkg::RES_UNMAP) begin
                if (at_start) begin
                    start_reg[idx_reg] <= rq_end_reg[AW-1:0];
                end else begin
                    end_reg[idx_reg] <= {1'b0, rq_addr_reg};
                end
            end
        end
    end

    // Result fields for the kind that the controller asks for
    always_comb begin
        res_next = '0;
        case (cmd.res_kind)
            mrt_pkg::RES_REJECT:   res_next.status = mrt_pkg::ST_REJECT;
            mrt_pkg::RES_NOREGION: res_next.status = mrt_pkg::ST_NOREGION;
            mrt_pkg::RES_NOSLOT:   res_next.status = mrt_pkg::ST_NOSLOT;
            mrt_pkg::RES_NOSPACE:  res_next.status = mrt_pkg::ST_NOSPACE;
            mrt_pkg::RES_MAP: begin
                res_next.status      = mrt_pkg::ST_OK;
                res_next.region_addr = cand_reg[AW-1:0];
                res_next.file_id_out = rq_fid_reg;
            end
            mrt_pkg::RES_UNMAP: begin
                res_next.status       = mrt_pkg::ST_OK;
                res_next.region_addr  = rq_addr_reg;
                res_next.file_offset  = rq_addr_reg - ent_base;
                res_next.page_count   = mrt_pkg::PC_W'(rq_len_reg >> mrt_pkg::PAGE_SHIFT);
                res_next.write_back   = shr_reg[idx_reg];
                res_next.file_id_out  = file_reg[idx_reg];
                res_next.region_freed = at_start && (rq_end_reg == ent_end);
            end
            mrt_pkg::RES_FAULT: begin
                res_next.status      = mrt_pkg::ST_OK;
                res_next.region_addr = page;
                res_next.file_offset = page - ent_base;
                res_next.page_count  = mrt_pkg::PC_W'(1);
                res_next.perm_read   = perm_reg[idx_reg][0];
                res_next.perm_write  = perm_reg[idx_reg][1];
                res_next.file_id_out = file_reg[idx_reg];
            end
            default: res_next.status = mrt_pkg::ST_REJECT;
        endcase
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (cmd.res_en) begin
            res <= res_next;
        end
    end

endmodule

### hdl/mapped_region_table.sv
// Top level of the mapped region table: ports, output register and instances.
// Each request gives one result. A fault lookup or unmap walks the table one
// slot a cycle and stops at the first hit; a map request sweeps all 16 slots
// per placement pass and repeats the pass until the candidate address stops
// moving. With at most 15 regions live when a placement runs there are at
// most 16 passes. Each scan step reads the table entry under the scan index.
// A finished result waits in an output register, and a new request is taken
// once the previous result has moved there. There is no clearing pass after
// reset. The min_address register may be written at any time the block is
// idle.
module mapped_region_table (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // addr, length, file_offset_in, prot, shared, file_readable,
    // file_writable, file_id, zero pad
    input  logic [127:0] s_axis_tdata,
    // req_type
    input  logic [1:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // region_addr, file_offset, page_count, perm_read, perm_write,
    // write_back, file_id_out, region_freed, zero pad
    output logic [127:0] m_axis_tdata,
    // status
    output logic [2:0]   m_axis_tuser,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [37:0]  cfg_data
);

    mrt_pkg::cmd_t cmd;
    mrt_pkg::sts_t sts;
    mrt_pkg::res_t res;
    logic          push;
    logic          out_free;
    logic          m_valid_reg;
    logic [127:0]  m_tdata_reg;
    logic [2:0]    m_tuser_reg;

    assign cfg_ready = 1'b1;
    assign out_free  = !m_valid_reg || m_axis_tready;

    mrt_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .out_free (out_free),
        .push     (push),
        .sts      (sts),
        .cmd      (cmd)
    );

    mrt_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .in_tdata  (s_axis_tdata),
        .in_tuser  (s_axis_tuser),
        .cmd       (cmd),
        .sts       (sts),
        .res       (res)
    );

    // Output register: holds a result until its transfer completes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (push) begin
            m_valid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            m_tdata_reg <= {14'b0, res.region_freed, res.file_id_out, res.write_back,
                            res.perm_write, res.perm_read, res.page_count,
                            res.file_offset, res.region_addr};
            m_tuser_reg <= res.status;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_tdata_reg;
    assign m_axis_tuser  = m_tuser_reg;

endmodule
